FILE: hw/rtl/circle_vs_box_or_circle_collision_defines.svh
// assertion macros for the circle vs body collision block
// included by the top level; no other dependencies
`ifndef CIRCLE_VS_BOX_OR_CIRCLE_COLLISION_DEFINES_SVH
`define CIRCLE_VS_BOX_OR_CIRCLE_COLLISION_DEFINES_SVH

// same-cycle implication
`define CVB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("collision block assertion failed");

// next-cycle implication
`define CVB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("collision block assertion failed");

`endif

FILE: hw/rtl/cvb_pkg.sv
// widths, constants and pipeline sideband type for the collision block
// used by every module of the block; depends on nothing
package cvb_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int FRAC_BITS   = 12;
   localparam int EXTRA_BITS  = 32 - COORD_WIDTH;
   localparam int NORM_FRAC   = 15;
   localparam int NORM_W      = 16;
   localparam int ROOT_W      = COORD_WIDTH + EXTRA_BITS;
   localparam int SQ_W        = 2 * ROOT_W;
   localparam int NUM_W       = COORD_WIDTH + NORM_FRAC + EXTRA_BITS;
   localparam int Q_W         = NORM_FRAC + 1;

   localparam logic signed [NORM_W-1:0] NORM_MAX = 16'sh7FFF;
   localparam logic [COORD_WIDTH-1:0] PEN_ONE = COORD_WIDTH'(1) << FRAC_BITS;

   typedef struct packed {
      logic                   valid;
      logic                   hit;
      logic                   zero;
      logic                   box;
      logic                   one_clamp;
      logic                   neg_x;
      logic                   neg_y;
      logic [COORD_WIDTH-1:0] ax;
      logic [COORD_WIDTH-1:0] ay;
      logic [COORD_WIDTH-1:0] lim;
      logic [ROOT_W-1:0]      root;
   } side_type;

endpackage

FILE: hw/rtl/cvb_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on cvb_pkg
module cvb_sqrt
   import cvb_pkg::*;
(
   input  logic              clock,
   input  logic              enable,
   input  logic [SQ_W-1:0]   value,
   output logic [ROOT_W-1:0] root
);

   logic [SQ_W-1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int B = ROOT_W - 1 - k;
      logic [SQ_W-1:0]   rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SQ_W:0]     trial;
      logic [SQ_W-1:0]   rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = value;
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
      assign trial = ((SQ_W+1)'(root_prev) << (B + 1)) | ((SQ_W+1)'(1) << (2 * B));

      always_comb begin
         if ({1'b0, rem_prev} >= trial) begin
            rem_in  = SQ_W'({1'b0, rem_prev} - trial);
            root_in = root_prev | (ROOT_W'(1) << B);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

FILE: hw/rtl/cvb_div.sv
// pipelined restoring divider for one normal component, one quotient bit per stage
// depends on cvb_pkg
module cvb_div
   import cvb_pkg::*;
(
   input  logic              clock,
   input  logic              enable,
   input  logic [NUM_W-1:0]  num,
   input  logic [ROOT_W-1:0] den,
   output logic [Q_W-1:0]    quot
);

   logic [NUM_W-1:0]  rem_ff  [Q_W];
   logic [ROOT_W-1:0] den_ff  [Q_W];
   logic [Q_W-1:0]    quot_ff [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      localparam int B = Q_W - 1 - k;
      logic [NUM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] den_prev;
      logic [Q_W-1:0]    quot_prev;
      logic [NUM_W:0]    shifted;
      logic [NUM_W-1:0]  rem_in;
      logic [Q_W-1:0]    quot_in;

      if (k == 0) begin : g_first
         assign rem_prev  = num;
         assign den_prev  = den;
         assign quot_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign quot_prev = quot_ff[k-1];
      end

      assign shifted = (NUM_W+1)'(den_prev) << B;

      always_comb begin
         if ({1'b0, rem_prev} >= shifted) begin
            rem_in  = NUM_W'({1'b0, rem_prev} - shifted);
            quot_in = quot_prev | (Q_W'(1) << B);
         end else begin
            rem_in  = rem_prev;
            quot_in = quot_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_prev;
            quot_ff[k] <= quot_in;
         end
      end
   end

   assign quot = quot_ff[Q_W-1];

endmodule

FILE: hw/rtl/circle_vs_box_or_circle_collision.sv
// Circle versus box-or-circle overlap test, fully pipelined: one item accepted per clock while not
// stalled; each result passes 5 geometry stages, 32 square-root stages giving one root bit each,
// 16 divider stages giving one normal bit each and one output register.
// A stall on a valid result (rsp_stall) freezes the whole pipeline and is seen as req_stall.
// depends on cvb_pkg, cvb_sqrt, cvb_div and the assertion macro header
`include "circle_vs_box_or_circle_collision_defines.svh"

module circle_vs_box_or_circle_collision
   import cvb_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_circle_x,
   input  logic signed [COORD_WIDTH-1:0] req_circle_y,
   input  logic [COORD_WIDTH-2:0]        req_radius,
   input  logic signed [COORD_WIDTH-1:0] req_body_x,
   input  logic signed [COORD_WIDTH-1:0] req_body_y,
   input  logic [COORD_WIDTH-2:0]        req_half_extent_x,
   input  logic [COORD_WIDTH-2:0]        req_half_extent_y,
   input  logic                          req_is_box,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic signed [NORM_W-1:0]      rsp_normal_x,
   output logic signed [NORM_W-1:0]      rsp_normal_y,
   output logic [COORD_WIDTH-1:0]        rsp_penetration,
   output logic                          rsp_axis_aligned
);

   localparam int PW = COORD_WIDTH + 1;
   localparam int DW = 2 * COORD_WIDTH;

   logic enable;
   logic rsp_valid_ff;
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   // stage 1: relative position and limit
   logic                   v1_ff, box1_ff;
   logic signed [PW-1:0]   px1_ff, py1_ff;
   logic [COORD_WIDTH-2:0] hx1_ff, hy1_ff;
   logic [COORD_WIDTH-1:0] lim1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (enable) v1_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         box1_ff <= req_is_box;
         px1_ff  <= PW'(req_circle_x) - PW'(req_body_x);
         py1_ff  <= PW'(req_circle_y) - PW'(req_body_y);
         hx1_ff  <= req_half_extent_x;
         hy1_ff  <= req_half_extent_y;
         lim1_ff <= req_is_box ? {1'b0, req_radius}
                               : {1'b0, req_radius} + {1'b0, req_half_extent_x};
      end
   end

   // stage 2: clamp to the box (box bodies only; circles pass through)
   logic                   v2_ff, box2_ff, one2_ff;
   logic signed [PW-1:0]   dx2_ff, dy2_ff;
   logic [COORD_WIDTH-1:0] lim2_ff;
   logic signed [PW-1:0]   hxs, hys, dx2_in, dy2_in;
   logic                   clx, cly;

   assign hxs = signed'({2'b00, hx1_ff});
   assign hys = signed'({2'b00, hy1_ff});

   always_comb begin
      dx2_in = px1_ff;
      dy2_in = py1_ff;
      clx    = 1'b0;
      cly    = 1'b0;
      if (box1_ff) begin
         if (px1_ff < -hxs) begin
            dx2_in = px1_ff + hxs;
            clx    = 1'b1;
         end else if (px1_ff > hxs) begin
            dx2_in = px1_ff - hxs;
            clx    = 1'b1;
         end else begin
            dx2_in = '0;
         end
         if (py1_ff < -hys) begin
            dy2_in = py1_ff + hys;
            cly    = 1'b1;
         end else if (py1_ff > hys) begin
            dy2_in = py1_ff - hys;
            cly    = 1'b1;
         end else begin
            dy2_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (enable) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         box2_ff <= box1_ff;
         one2_ff <= clx ^ cly;
         dx2_ff  <= dx2_in;
         dy2_ff  <= dy2_in;
         lim2_ff <= lim1_ff;
      end
   end

   // stage 3: magnitudes and per-axis limit check
   logic                   v3_ff, box3_ff, one3_ff, negx3_ff, negy3_ff, ok3_ff;
   logic [COORD_WIDTH-1:0] ax3_ff, ay3_ff, lim3_ff;
   logic [PW-1:0]          absx, absy;

   assign absx = dx2_ff[PW-1] ? PW'(-dx2_ff) : PW'(dx2_ff);
   assign absy = dy2_ff[PW-1] ? PW'(-dy2_ff) : PW'(dy2_ff);

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (enable) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         box3_ff  <= box2_ff;
         one3_ff  <= one2_ff;
         negx3_ff <= dx2_ff[PW-1];
         negy3_ff <= dy2_ff[PW-1];
         ax3_ff   <= absx[COORD_WIDTH-1:0];
         ay3_ff   <= absy[COORD_WIDTH-1:0];
         ok3_ff   <= (absx < PW'(lim2_ff)) && (absy < PW'(lim2_ff));
         lim3_ff  <= lim2_ff;
      end
   end

   // stage 4: squares
   logic                   v4_ff, box4_ff, one4_ff, negx4_ff, negy4_ff, ok4_ff;
   logic [COORD_WIDTH-1:0] ax4_ff, ay4_ff, lim4_ff;
   logic [DW-1:0]          sx4_ff, sy4_ff, lsq4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (enable) v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         box4_ff  <= box3_ff;
         one4_ff  <= one3_ff;
         negx4_ff <= negx3_ff;
         negy4_ff <= negy3_ff;
         ok4_ff   <= ok3_ff;
         ax4_ff   <= ax3_ff;
         ay4_ff   <= ay3_ff;
         lim4_ff  <= lim3_ff;
         sx4_ff   <= DW'(ax3_ff) * DW'(ax3_ff);
         sy4_ff   <= DW'(ay3_ff) * DW'(ay3_ff);
         lsq4_ff  <= DW'(lim3_ff) * DW'(lim3_ff);
      end
   end

   // stage 5: squared distance and hit decision
   side_type      side5_ff;
   logic [DW-1:0] d25_ff;
   logic [DW:0]   d2_sum;

   assign d2_sum = {1'b0, sx4_ff} + {1'b0, sy4_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         side5_ff.valid <= 1'b0;
      end else if (enable) begin
         side5_ff.valid     <= v4_ff;
         side5_ff.hit       <= ok4_ff && (d2_sum < {1'b0, lsq4_ff});
         side5_ff.zero      <= (d2_sum == '0);
         side5_ff.box       <= box4_ff;
         side5_ff.one_clamp <= one4_ff;
         side5_ff.neg_x     <= negx4_ff;
         side5_ff.neg_y     <= negy4_ff;
         side5_ff.ax        <= ax4_ff;
         side5_ff.ay        <= ay4_ff;
         side5_ff.lim       <= lim4_ff;
         side5_ff.root      <= '0;
         d25_ff             <= d2_sum[DW-1:0];
      end
   end

   // square root with the sideband riding alongside
   logic [ROOT_W-1:0] root;
   side_type          sq_ff [ROOT_W];

   cvb_sqrt u_sqrt (
      .clock  (clock),
      .enable (enable),
      .value  ({d25_ff, (SQ_W-DW)'(0)}),
      .root   (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROOT_W; i++) sq_ff[i].valid <= 1'b0;
      end else if (enable) begin
         sq_ff[0] <= side5_ff;
         for (int i = 1; i < ROOT_W; i++) sq_ff[i] <= sq_ff[i-1];
      end
   end

   // normal division, both axes in parallel
   side_type       sd_in;
   side_type       dv_ff [Q_W];
   logic [Q_W-1:0] qx, qy;

   always_comb begin
      sd_in      = sq_ff[ROOT_W-1];
      sd_in.root = root;
   end

   cvb_div u_div_x (
      .clock  (clock),
      .enable (enable),
      .num    ({sd_in.ax, (NUM_W-COORD_WIDTH)'(0)}),
      .den    (root),
      .quot   (qx)
   );

   cvb_div u_div_y (
      .clock  (clock),
      .enable (enable),
      .num    ({sd_in.ay, (NUM_W-COORD_WIDTH)'(0)}),
      .den    (root),
      .quot   (qy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Q_W; i++) dv_ff[i].valid <= 1'b0;
      end else if (enable) begin
         dv_ff[0] <= sd_in;
         for (int i = 1; i < Q_W; i++) dv_ff[i] <= dv_ff[i-1];
      end
   end

   // output register: sign, saturation and special cases
   side_type                 fin;
   logic signed [NORM_W:0]   sqx, sqy;
   logic signed [NORM_W-1:0] nx_sat, ny_sat, nx_in, ny_in;
   logic [COORD_WIDTH-1:0]   pen_in;
   logic                     axis_in;
   logic                     hit_ff, axis_ff;
   logic signed [NORM_W-1:0] nx_ff, ny_ff;
   logic [COORD_WIDTH-1:0]   pen_ff;

   assign fin = dv_ff[Q_W-1];
   assign sqx = fin.neg_x ? -signed'({1'b0, qx}) : signed'({1'b0, qx});
   assign sqy = fin.neg_y ? -signed'({1'b0, qy}) : signed'({1'b0, qy});
   // quotient never exceeds one, so only the positive side can overflow
   assign nx_sat = (sqx > (NORM_W+1)'(NORM_MAX)) ? NORM_MAX : sqx[NORM_W-1:0];
   assign ny_sat = (sqy > (NORM_W+1)'(NORM_MAX)) ? NORM_MAX : sqy[NORM_W-1:0];

   always_comb begin
      nx_in   = '0;
      ny_in   = '0;
      pen_in  = '0;
      axis_in = 1'b0;
      if (fin.hit) begin
         if (fin.zero) begin
            nx_in  = NORM_MAX;
            pen_in = fin.box ? '0 : PEN_ONE;
         end else begin
            nx_in   = nx_sat;
            ny_in   = ny_sat;
            pen_in  = fin.lim - fin.root[ROOT_W-1:EXTRA_BITS];
            axis_in = fin.box && fin.one_clamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (enable) rsp_valid_ff <= fin.valid;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hit_ff  <= fin.hit;
         nx_ff   <= nx_in;
         ny_ff   <= ny_in;
         pen_ff  <= pen_in;
         axis_ff <= axis_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = hit_ff;
   assign rsp_normal_x     = nx_ff;
   assign rsp_normal_y     = ny_ff;
   assign rsp_penetration  = pen_ff;
   assign rsp_axis_aligned = axis_ff;

   `CVB_ASSERT_IMPL(a_miss_zero, clock, reset, rsp_valid && !rsp_hit,
      rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_penetration == 0 && !rsp_axis_aligned)
   `CVB_ASSERT_IMPL(a_axis_hit, clock, reset, rsp_valid && rsp_axis_aligned,
      rsp_hit && (rsp_normal_x == 0 || rsp_normal_y == 0))
   `CVB_ASSERT_IMPL(a_stall_back, clock, reset, rsp_valid && rsp_stall, req_stall)
   `CVB_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_penetration) && $stable(rsp_normal_x))

endmodule
